// ----- sv/spsi_pkg.sv -----
// ----------------------------------------------------------------------------
// spsi_pkg
// Shared types, constants and codes of the sinc-interpolating sample player.
// ----------------------------------------------------------------------------
package spsi_pkg;

    localparam int WaveDepth  = 65536;
    localparam int WaveAw     = $clog2(WaveDepth);
    localparam int Taps       = 16;
    localparam int Phases     = 256;
    localparam int BaseDepth  = (Phases + 1) * Taps;
    localparam int SlopeDepth = Phases * Taps;
    localparam int CoefAw     = $clog2(BaseDepth);
    localparam int SlopeAw    = $clog2(SlopeDepth);
    localparam int TapAw      = $clog2(Taps);
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    localparam logic [2:0] FUNC_WR_LEFT  = 3'd0;
    localparam logic [2:0] FUNC_WR_RIGHT = 3'd1;
    localparam logic [2:0] FUNC_WR_BASE  = 3'd2;
    localparam logic [2:0] FUNC_WR_SLOPE = 3'd3;
    localparam logic [2:0] FUNC_PLAY     = 3'd4;

    localparam logic [2:0] REG_LOWER = 3'd0;
    localparam logic [2:0] REG_UPPER = 3'd1;
    localparam logic [2:0] REG_WSIZE = 3'd2;
    localparam logic [2:0] REG_PITCH = 3'd3;
    localparam logic [2:0] REG_MODE  = 3'd4;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_LOOP    = 2'd1;
    localparam logic [1:0] MODE_BIDIR   = 2'd2;
    localparam logic [1:0] MODE_ONESHOT = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] addr;
        logic [15:0] data;
    } in_word_t;

    typedef struct packed {
        logic [31:0] left_sum;
        logic [31:0] right_sum;
        logic        finished;
        logic [15:0] position_out;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } cfg_word_t;

    typedef struct packed {
        logic [15:0] lower_bound;
        logic [15:0] upper_bound;
        logic [15:0] wave_size;
        logic [31:0] pitch_ratio;
        logic [1:0]  play_mode;
    } cfg_regs_t;

endpackage

// ----- sv/spsi_if.sv -----
// ----------------------------------------------------------------------------
// spsi_if
// Generic valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface spsi_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/spsi_ram.sv -----
// ----------------------------------------------------------------------------
// spsi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module spsi_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- sv/spsi_front.sv -----
// ----------------------------------------------------------------------------
// spsi_front
// Accepts input words, drops unused codes and queues the rest for the engine.
// ----------------------------------------------------------------------------
module spsi_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spsi_pkg::in_word_t   in_word,
    output logic                 q_valid,
    input  logic                 q_take,
    output spsi_pkg::in_word_t   q_word
);
    import spsi_pkg::*;

    in_word_t             buf_reg [QueueDepth];
    logic [QueueAw-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [QueueAw:0]     cnt_reg, cnt_next;
    logic                 push;

    assign in_ready = (cnt_reg != QueueAw'(0) + (QueueAw+1)'(QueueDepth)) ;
    assign push     = in_valid && in_ready && (in_word.func <= FUNC_PLAY);
    assign q_valid  = (cnt_reg != '0);
    assign q_word   = buf_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = q_take ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QueueAw+1)'(push) - (QueueAw+1)'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_word;
        end
    end
endmodule

// ----- sv/spsi_engine.sv -----
// ----------------------------------------------------------------------------
// spsi_engine
// Carries out memory writes and the sixteen-tap interpolation of play words,
// then advances the playback position and applies the play mode.
// ----------------------------------------------------------------------------
module spsi_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spsi_pkg::cfg_regs_t  regs,
    input  logic                 q_valid,
    output logic                 q_take,
    input  spsi_pkg::in_word_t   q_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output spsi_pkg::out_word_t  out_word
);
    import spsi_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MAC  = 3'd3;
    localparam logic [2:0] ST_ADV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]        st_reg, st_next;
    logic [TapAw:0]    k_reg;
    logic              rd_vld_reg, mul_vld_reg, mac_vld_reg;
    logic [17:0]       pos_reg;
    logic [23:0]       frac_reg;
    logic              fwd_reg, done_reg;
    logic [31:0]       accl_reg, accr_reg;
    logic [31:0]       prod_reg;
    logic [15:0]       base1_reg, sl1_reg, sr1_reg;
    logic [15:0]       coef_reg;
    logic [15:0]       sl_reg, sr_reg;
    logic [15:0]       lsmp_d, rsmp_d, base_d, slope_d;
    out_word_t         obuf_reg;
    logic              ovalid_reg;

    logic              is_play, do_wr;
    logic              we_l, we_r, we_b, we_s;
    logic [WaveAw-1:0] wa;
    logic [CoefAw-1:0] ba;
    logic [SlopeAw-1:0] sa;
    logic [TapAw-1:0]  kk;

    assign is_play = (q_word.func == FUNC_PLAY);
    assign do_wr   = (st_reg == ST_IDLE) && q_valid && !is_play;
    assign kk      = k_reg[TapAw-1:0];
    assign we_l = do_wr && q_word.func == FUNC_WR_LEFT;
    assign we_r = do_wr && q_word.func == FUNC_WR_RIGHT;
    assign we_b = do_wr && q_word.func == FUNC_WR_BASE && {16'd0, q_word.addr} < 32'(BaseDepth);
    assign we_s = do_wr && q_word.func == FUNC_WR_SLOPE
                  && {16'd0, q_word.addr} < 32'(SlopeDepth);
    assign wa = do_wr ? q_word.addr[WaveAw-1:0] : pos_reg[WaveAw-1:0] + WaveAw'(kk);
    assign ba = do_wr ? q_word.addr[CoefAw-1:0] : CoefAw'({frac_reg[23:16], kk});
    assign sa = do_wr ? q_word.addr[SlopeAw-1:0] : {frac_reg[23:16], kk};

    spsi_ram #(.Width(16), .Depth(WaveDepth)) u_left (
        .clk(clk), .we(we_l), .addr(wa), .wdata(q_word.data), .rdata(lsmp_d));
    spsi_ram #(.Width(16), .Depth(WaveDepth)) u_right (
        .clk(clk), .we(we_r), .addr(wa), .wdata(q_word.data), .rdata(rsmp_d));
    spsi_ram #(.Width(16), .Depth(BaseDepth)) u_base (
        .clk(clk), .we(we_b), .addr(ba), .wdata(q_word.data), .rdata(base_d));
    spsi_ram #(.Width(16), .Depth(SlopeDepth)) u_slope (
        .clk(clk), .we(we_s), .addr(sa), .wdata(q_word.data), .rdata(slope_d));

    // Position update arithmetic.
    logic        rneg, eff_fwd, eff2_fwd;
    logic [31:0] mag;
    logic signed [33:0] sum;
    logic signed [19:0] pos_a, pos_f, span, lo_s, hi_s, ws_s;
    logic [23:0] frac_f;
    logic        done_f, fwd_f;

    always_comb
    begin
        rneg    = regs.pitch_ratio[31];
        mag     = rneg ? (~regs.pitch_ratio + 32'd1) : regs.pitch_ratio;
        eff_fwd = fwd_reg ^ rneg;
        sum     = eff_fwd ? $signed({10'd0, frac_reg}) + $signed({2'b00, mag})
                          : $signed({10'd0, frac_reg}) - $signed({2'b00, mag});
        pos_a   = $signed({2'b00, pos_reg}) + 20'(sum >>> 24);
        frac_f  = sum[23:0];
        lo_s    = $signed({4'd0, regs.lower_bound});
        hi_s    = $signed({4'd0, regs.upper_bound});
        ws_s    = $signed({4'd0, regs.wave_size});
        pos_f   = pos_a;
        done_f  = done_reg;
        fwd_f   = fwd_reg;
        eff2_fwd = eff_fwd;
        span    = hi_s - lo_s;
        if (span < 20'sd1)
        begin
            span = 20'sd1;
        end
        unique case (regs.play_mode)
            MODE_NORMAL:
            begin
                if (pos_f >= hi_s)
                begin
                    pos_f  = hi_s;
                    frac_f = '0;
                    done_f = 1'b1;
                end
                if (pos_f < lo_s)
                begin
                    pos_f  = lo_s;
                    frac_f = '0;
                end
            end
            MODE_LOOP:
            begin
                if (eff_fwd)
                begin
                    if (pos_f > hi_s)
                    begin
                        pos_f = pos_f - span;
                    end
                end
                else if (pos_f < lo_s)
                begin
                    pos_f = pos_f + span;
                end
                if (pos_f < 20'sd0 || pos_f > ws_s)
                begin
                    pos_f = hi_s;
                end
            end
            MODE_BIDIR:
            begin
                if (pos_f < lo_s)
                begin
                    eff2_fwd = 1'b1;
                end
                if (pos_f > hi_s)
                begin
                    eff2_fwd = 1'b0;
                end
                fwd_f = eff2_fwd ^ rneg;
                if (pos_f < 20'sd0)
                begin
                    pos_f = 20'sd0;
                end
                else if (pos_f > ws_s)
                begin
                    pos_f = ws_s;
                end
            end
            MODE_ONESHOT:
            begin
                if (pos_f < lo_s || pos_f > hi_s)
                begin
                    done_f = 1'b1;
                    if (pos_f < lo_s)
                    begin
                        pos_f = lo_s;
                    end
                    else
                    begin
                        pos_f = hi_s;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Coefficient and product pipeline (one tap per cycle).
    logic signed [31:0] cprod_l, cprod_r;
    assign cprod_l = $signed(coef_reg) * $signed(sl_reg);
    assign cprod_r = $signed(coef_reg) * $signed(sr_reg);

    always_comb
    begin
        st_next = st_reg;
        q_take  = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = !is_play || !ovalid_reg;
                    if (is_play && !ovalid_reg)
                    begin
                        st_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (k_reg == (TapAw+1)'(Taps - 1))
                begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                st_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (!rd_vld_reg && !mul_vld_reg && !mac_vld_reg)
                begin
                    st_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            k_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            mac_vld_reg <= 1'b0;
            pos_reg     <= '0;
            frac_reg    <= '0;
            fwd_reg     <= 1'b1;
            done_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            rd_vld_reg  <= (st_reg == ST_RUN);
            mul_vld_reg <= rd_vld_reg;
            mac_vld_reg <= mul_vld_reg;
            if (st_reg == ST_RUN)
            begin
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                k_reg <= '0;
            end
            if (st_reg == ST_ADV)
            begin
                pos_reg  <= 18'(pos_f);
                frac_reg <= frac_f;
                fwd_reg  <= fwd_f;
                done_reg <= done_f;
            end
            if (st_reg == ST_OUT)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg  <= $signed(slope_d) * $signed(frac_reg[15:0]);
            base1_reg <= base_d;
            sl1_reg   <= lsmp_d;
            sr1_reg   <= rsmp_d;
        end
        if (mul_vld_reg)
        begin
            coef_reg <= base1_reg + prod_reg[31:16];
            sl_reg   <= sl1_reg;
            sr_reg   <= sr1_reg;
        end
        if (st_reg == ST_IDLE)
        begin
            accl_reg <= '0;
            accr_reg <= '0;
        end
        else if (mac_vld_reg)
        begin
            accl_reg <= accl_reg + cprod_l;
            accr_reg <= accr_reg + cprod_r;
        end
        if (st_reg == ST_OUT)
        begin
            obuf_reg.left_sum     <= accl_reg;
            obuf_reg.right_sum    <= accr_reg;
            obuf_reg.finished     <= done_reg;
            obuf_reg.position_out <= pos_reg[15:0];
        end
    end

    assign out_valid = ovalid_reg;
    assign out_word  = obuf_reg;
endmodule

// ----- sv/sample_player_sinc_interpolator.sv -----
// ----------------------------------------------------------------------------
// sample_player_sinc_interpolator
// Stereo sample player with 256-phase, 16-tap windowed-sinc interpolation.
// A write word passes the input queue and reaches its RAM while the engine is
// idle, one word per cycle while it stays idle. A play word is taken only
// once the previous one is through: sixteen tap reads through the single-port
// RAMs, a three-stage multiply and accumulate pipeline, the position update
// and the output register. A waiting result word holds back the next play word.
// Reset clears position, fraction, finish flag, bounds and wave size, sets direction
// forward, pitch to 1.0 and mode to normal; the RAMs are undefined until written.
// ----------------------------------------------------------------------------
module sample_player_sinc_interpolator (
    input logic clk,
    input logic rst_n,
    spsi_if.sink   in_ch,
    spsi_if.sink   cfg_ch,
    spsi_if.source out_ch
);
    import spsi_pkg::*;

    cfg_regs_t regs_reg;
    in_word_t  q_word;
    logic      q_valid, q_take;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.lower_bound <= '0;
            regs_reg.upper_bound <= '0;
            regs_reg.wave_size   <= '0;
            regs_reg.pitch_ratio <= 32'h0100_0000;
            regs_reg.play_mode   <= MODE_NORMAL;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.payload.index)
                REG_LOWER: regs_reg.lower_bound <= cfg_ch.payload.value[15:0];
                REG_UPPER: regs_reg.upper_bound <= cfg_ch.payload.value[15:0];
                REG_WSIZE: regs_reg.wave_size   <= cfg_ch.payload.value[15:0];
                REG_PITCH: regs_reg.pitch_ratio <= cfg_ch.payload.value;
                REG_MODE:  regs_reg.play_mode   <= cfg_ch.payload.value[1:0];
                default:
                begin
                end
            endcase
        end
    end

    spsi_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_word(in_ch.payload),
        .q_valid(q_valid), .q_take(q_take), .q_word(q_word));

    spsi_engine u_engine (
        .clk(clk), .rst_n(rst_n), .regs(regs_reg),
        .q_valid(q_valid), .q_take(q_take), .q_word(q_word),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(out_ch.payload));
endmodule

// ----- tb/spsi_checker.sv -----
// ----------------------------------------------------------------------------
// spsi_checker
// Watches the input, configuration and output channels of the sample player.
// It keeps its own copy of the sample memories, coefficient tables, registers
// and play state, predicts each played frame and compares it with the block.
// ----------------------------------------------------------------------------
module spsi_checker
    import spsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spsi_if      in_ch,
    spsi_if      cfg_ch,
    spsi_if      out_ch,
    output int   error_count,
    output int   frames_pending,
    output int   frames_checked
);

    logic [15:0] left_mem  [WaveDepth];
    logic [15:0] right_mem [WaveDepth];
    logic [15:0] base_tab  [BaseDepth];
    logic [15:0] slope_tab [SlopeDepth];

    int          play_pos;
    logic [23:0] play_frac;
    logic        play_fwd;
    logic        done_seen;

    int          lower_lim;
    int          upper_lim;
    int          wave_len;
    logic [31:0] pitch;
    logic [1:0]  mode;

    out_word_t   frame_q[$];

    function automatic int sx16(logic [15:0] v);
        return int'(signed'(v));
    endfunction

    function automatic int clamp(int x, int lo, int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    task automatic render_frame(output out_word_t frame);
        logic [7:0]  phase;
        int          lip;
        int          c;
        int          span;
        int          eff;
        int          rsign;
        int          pos;
        longint      prod;
        longint      mag;
        longint      sum;
        logic [15:0] c16;
        logic [15:0] si;
        logic [31:0] accl;
        logic [31:0] accr;
        phase = play_frac[23:16];
        lip   = sx16(play_frac[15:0]);
        accl  = '0;
        accr  = '0;
        for (int k = 0; k < Taps; k++)
        begin
            prod = longint'(sx16(slope_tab[phase * Taps + k])) * longint'(lip);
            c16  = 16'((prod >>> 16) + longint'(sx16(base_tab[phase * Taps + k])));
            c    = sx16(c16);
            si   = 16'(play_pos + k);
            accl = accl + 32'(c * sx16(left_mem[si]));
            accr = accr + 32'(c * sx16(right_mem[si]));
        end
        if (pitch[31])
        begin
            rsign = -1;
            mag   = 64'sd4294967296 - longint'(pitch);
        end
        else
        begin
            rsign = 1;
            mag   = longint'(pitch);
        end
        eff       = (play_fwd ? 1 : -1) * rsign;
        sum       = longint'(play_frac) + ((eff > 0) ? mag : -mag);
        pos       = play_pos + int'(sum >>> 24);
        play_frac = sum[23:0];
        case (mode)
            MODE_NORMAL:
            begin
                if (pos >= upper_lim)
                begin
                    pos       = upper_lim;
                    play_frac = '0;
                    done_seen = 1'b1;
                end
                if (pos < lower_lim)
                begin
                    pos       = lower_lim;
                    play_frac = '0;
                end
            end
            MODE_LOOP:
            begin
                span = upper_lim - lower_lim;
                if (span < 1) span = 1;
                if (eff > 0)
                begin
                    if (pos > upper_lim) pos -= span;
                end
                else
                begin
                    if (pos < lower_lim) pos += span;
                end
                if (pos < 0 || pos > wave_len) pos = upper_lim;
            end
            MODE_BIDIR:
            begin
                if (pos < lower_lim) eff = 1;
                if (pos > upper_lim) eff = -1;
                play_fwd = (eff * rsign) > 0;
                pos      = clamp(pos, 0, wave_len);
            end
            default:
            begin
                if (pos < lower_lim || pos > upper_lim)
                begin
                    done_seen = 1'b1;
                    pos       = clamp(pos, lower_lim, upper_lim);
                end
            end
        endcase
        play_pos           = pos;
        frame.left_sum     = accl;
        frame.right_sum    = accr;
        frame.finished     = done_seen;
        frame.position_out = 16'(play_pos);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_f;
        out_word_t got_f;
        in_word_t  w;
        cfg_word_t cw;
        if (!rst_n)
        begin
            play_pos       = 0;
            play_frac      = '0;
            play_fwd       = 1'b1;
            done_seen      = 1'b0;
            lower_lim      = 0;
            upper_lim      = 0;
            wave_len       = 0;
            pitch          = 32'h0100_0000;
            mode           = MODE_NORMAL;
            error_count    = 0;
            frames_checked = 0;
            frame_q.delete();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                cw = cfg_ch.payload;
                case (cw.index)
                    REG_LOWER: lower_lim = int'(cw.value[15:0]);
                    REG_UPPER: upper_lim = int'(cw.value[15:0]);
                    REG_WSIZE: wave_len  = int'(cw.value[15:0]);
                    REG_PITCH: pitch     = cw.value;
                    REG_MODE:  mode      = cw.value[1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                w = in_ch.payload;
                case (w.func)
                    FUNC_WR_LEFT:  left_mem[w.addr] = w.data;
                    FUNC_WR_RIGHT: right_mem[w.addr] = w.data;
                    FUNC_WR_BASE:  if (w.addr < BaseDepth) base_tab[w.addr] = w.data;
                    FUNC_WR_SLOPE: if (w.addr < SlopeDepth) slope_tab[w.addr] = w.data;
                    FUNC_PLAY:
                    begin
                        render_frame(exp_f);
                        frame_q.push_back(exp_f);
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got_f = out_ch.payload;
                if (frame_q.size() == 0)
                begin
                    $error("Output word with no frame expected");
                    error_count++;
                end
                else
                begin
                    exp_f = frame_q.pop_front();
                    frames_checked++;
                    if (got_f.left_sum !== exp_f.left_sum)
                    begin
                        $error("left_sum: expected %h, got %h", exp_f.left_sum, got_f.left_sum);
                        error_count++;
                    end
                    if (got_f.right_sum !== exp_f.right_sum)
                    begin
                        $error("right_sum: expected %h, got %h",
                               exp_f.right_sum, got_f.right_sum);
                        error_count++;
                    end
                    if (got_f.finished !== exp_f.finished)
                    begin
                        $error("finished: expected %b, got %b", exp_f.finished, got_f.finished);
                        error_count++;
                    end
                    if (got_f.position_out !== exp_f.position_out)
                    begin
                        $error("position_out: expected %0d, got %0d",
                               exp_f.position_out, got_f.position_out);
                        error_count++;
                    end
                end
            end
        end
        frames_pending = frame_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sinc-interpolating sample player. The sample region that
// playback can reach and the coefficient rows around phase zero are filled
// first; pitch values keep a small fractional step so that the phase stays in
// those rows. Directed and random words then run under several register
// settings and handshake idling patterns; a checker does the rest.
// ----------------------------------------------------------------------------
module tb_top;
    import spsi_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int Drain      = 40;
    localparam int WaveFill   = 128;
    localparam int PosLimit   = 112;

    logic clk;
    logic rst_n;
    int   cycles;
    int   in_idle;
    int   out_idle;
    logic long_hold_go;
    int   error_count;
    int   frames_pending;
    int   frames_checked;
    int   settings_done;

    spsi_if #(.payload_t(in_word_t))  in_ch();
    spsi_if #(.payload_t(cfg_word_t)) cfg_ch();
    spsi_if #(.payload_t(out_word_t)) out_ch();

    sample_player_sinc_interpolator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    spsi_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .cfg_ch         (cfg_ch),
        .out_ch         (out_ch),
        .error_count    (error_count),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        static int hold_left = 0;
        static bit hold_used = 0;
        if (long_hold_go && !hold_used)
        begin
            hold_used = 1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= out_idle);
        end
    end

    function automatic logic [15:0] rand_data();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(logic [2:0] func, logic [15:0] addr, logic [15:0] data);
        in_word_t w;
        w.func = func;
        w.addr = addr;
        w.data = data;
        while ($urandom_range(99) < in_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        cfg_word_t cw;
        cw.index = index;
        cw.value = value;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= cw;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0) @(posedge clk);
        repeat (Drain) @(posedge clk);
    endtask

    task automatic apply_setting(int lo, int hi, int ws, logic [31:0] p, logic [1:0] m);
        settle();
        write_reg(REG_LOWER, 32'(lo));
        write_reg(REG_UPPER, 32'(hi));
        write_reg(REG_WSIZE, 32'(ws));
        write_reg(REG_PITCH, p);
        write_reg(REG_MODE, {30'b0, m});
        cfg_ch.valid <= 1'b0;
        settings_done++;
    endtask

    task automatic play(int n);
        repeat (n) send_word(FUNC_PLAY, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [31:0] rand_pitch();
        logic [31:0] p;
        logic [23:0] f;
        f = 24'($urandom_range(150));
        case ($urandom_range(5))
            0:       p = {1'b0, 7'($urandom), f};
            1:       p = {8'h00, f};
            default: p = {6'b0, 2'($urandom_range(3)), f};
        endcase
        if ($urandom_range(1)) p = -p;
        return p;
    endfunction

    initial
    begin
        int lo;
        int hi;
        int ws;
        int row;
        rst_n          = 1'b0;
        cycles         = 0;
        in_idle        = 0;
        out_idle       = 0;
        long_hold_go   = 1'b0;
        settings_done  = 0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        out_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < 4; r++)
        begin
            row = (r < 2) ? r : Phases - 4 + r;
            for (int k = 0; k < Taps; k++)
            begin
                send_word(FUNC_WR_BASE, 16'(row * Taps + k), rand_data());
                send_word(FUNC_WR_SLOPE, 16'(row * Taps + k), rand_data());
            end
        end
        for (int a = 0; a < WaveFill; a++)
        begin
            send_word(FUNC_WR_LEFT, 16'(a), rand_data());
            send_word(FUNC_WR_RIGHT, 16'(a), rand_data());
        end
        send_word(FUNC_WR_LEFT, 16'hffff, rand_data());
        send_word(FUNC_WR_RIGHT, 16'hffff, rand_data());

        // Reset registers first, then sample edges, table edges and unused codes.
        play(2);
        apply_setting(0, 40, 100, 32'h0100_0000, MODE_NORMAL);
        send_word(FUNC_WR_LEFT, 16'h0000, 16'h8000);
        send_word(FUNC_WR_RIGHT, 16'hffff, 16'h7fff);
        send_word(FUNC_WR_BASE, 16'(BaseDepth - 1), 16'h7fff);
        send_word(FUNC_WR_BASE, 16'(BaseDepth), 16'h1234);
        send_word(FUNC_WR_SLOPE, 16'(SlopeDepth - 1), 16'h8000);
        send_word(FUNC_WR_SLOPE, 16'hffff, 16'h4321);
        send_word(3'd5, 16'hffff, 16'hffff);
        send_word(3'd6, 16'h0000, 16'h0000);
        send_word(3'd7, 16'h5555, 16'haaaa);
        play(3);
        apply_setting(10, 20, 60, 32'h0200_0100, MODE_LOOP);
        play(3);
        apply_setting(5, 30, 100, 32'h7f00_0003, MODE_BIDIR);
        play(3);
        apply_setting(30, 5, 40, 32'h8000_0000, MODE_ONESHOT);
        play(3);
        apply_setting(65535, 65535, 65535, 32'hff00_0000, MODE_NORMAL);
        play(3);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin in_idle = 0;  out_idle = 0;  end
                1: begin in_idle = 49; out_idle = 0;  end
                2: begin in_idle = 0;  out_idle = 49; end
                default: begin in_idle = 14; out_idle = 14; end
            endcase
            lo = $urandom_range(100);
            hi = $urandom_range(PosLimit);
            ws = $urandom_range(PosLimit);
            apply_setting(lo, hi, ws, rand_pitch(), 2'(ph));
            if (ph == 2) long_hold_go <= 1'b1;
            for (int n = 0; n < 25; n++)
            begin
                case ($urandom_range(19))
                    0:  send_word(FUNC_WR_LEFT, 16'($urandom), rand_data());
                    1:  send_word(FUNC_WR_RIGHT, 16'($urandom), rand_data());
                    2:  send_word(FUNC_WR_BASE, 16'($urandom_range(BaseDepth + 50)), rand_data());
                    3:  send_word(FUNC_WR_SLOPE, 16'($urandom_range(SlopeDepth + 50)),
                                  rand_data());
                    4:  send_word(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom));
                    default: play(1);
                endcase
            end
        end

        settle();
        $display("Checked %0d frames over %0d register settings in all four play modes,",
                 frames_checked, settings_done);
        $display("with sample reads wrapping past the top and four handshake idling patterns.");
        if (error_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
